@@ rtl/core/ricmp_pkg.sv @@
package ricmp_pkg;

    localparam int MAX_LEN_DEF    = 64;
    localparam int GEN_DIGITS_DEF = 8;

    localparam logic [7:0] HYPHEN     = 8'h2D;
    localparam logic [7:0] DIGIT_LOW  = 8'h30;
    localparam logic [7:0] DIGIT_HIGH = 8'h39;

    typedef logic signed [1:0] order_t;

    localparam order_t ORD_LT = 2'sb11;
    localparam order_t ORD_EQ = 2'sb00;
    localparam order_t ORD_GT = 2'sb01;

    function automatic order_t byte_cmp(input logic [7:0] a, input logic [7:0] b);
        order_t r;
        if (a < b)
        begin
            r = ORD_LT;
        end
        else if (a > b)
        begin
            r = ORD_GT;
        end
        else
        begin
            r = ORD_EQ;
        end
        return r;
    endfunction

endpackage

@@ rtl/core/revision_id_compare.sv @@
// Revision ID comparator.
// Input stream: one beat per ID byte. s_axis_tuser selects the ID (0 first,
// 1 second), s_axis_tdata carries the byte and a has-byte flag, and
// s_axis_tlast ends an ID. Send the whole first ID, then the second ID.
// A first-ID beat after the first ID has closed starts a new pair.
// Output stream: one beat per pair, issued for the beat that ends the second
// ID. m_axis_tdata carries the order (-1, 0, +1, two's complement) and
// m_axis_tuser flags an ID longer than MAX_LEN bytes (order then 0).
// Throughput: one input beat per cycle while s_axis_tready is high. Each
// second-ID beat reads the first-ID buffer at two addresses (whole and
// suffix position); the read data is registered and feeds the compare stage.
// The last beat of the second ID is registered in the compare stage, and the
// result beat is then registered in the output register.
// Reset clears all tracking state and the output valid flag; the byte buffer
// is not cleared and is only read at positions of the current first ID.
// When the receiver stalls, the result waits in the output register and
// input beats keep flowing until a second result is ready to leave the
// compare stage; s_axis_tready then drops until the output is taken.
module revision_id_compare #(
    parameter int MAX_LEN    = ricmp_pkg::MAX_LEN_DEF,
    parameter int GEN_DIGITS = ricmp_pkg::GEN_DIGITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] byte_value, [8] has_byte, [15:9] zero
    input  logic [0:0]  s_axis_tuser,   // [0] req_type
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [1:0] order, [7:2] zero
    output logic [0:0]  m_axis_tuser    // [0] too_long
);

    localparam int LEN_W = $clog2(MAX_LEN + 1);
    localparam int AW    = $clog2(MAX_LEN);
    localparam int GEN_W = $clog2(10 ** GEN_DIGITS);

    logic [7:0] mem [MAX_LEN];

    // live tracking state
    logic [LEN_W-1:0] f_len_reg, f_hpos_reg, s_len_reg, s_hpos_reg;
    logic             f_hseen_reg, f_dok_reg, s_hseen_reg, s_dok_reg;
    logic [GEN_W-1:0] f_gen_reg, s_gen_reg;
    logic             closed_reg, ovf_reg;

    logic [LEN_W-1:0] f_len_next, f_hpos_next, s_len_next, s_hpos_next;
    logic             f_hseen_next, f_dok_next, s_hseen_next, s_dok_next;
    logic [GEN_W-1:0] f_gen_next, s_gen_next;
    logic             closed_next, ovf_next;

    // compare stage
    logic             s1_valid_reg, s1_clr_reg, s1_res_reg;
    logic             s1_whole_en_reg, s1_suf_en_reg;
    logic [7:0]       s1_byte_reg, rd_w_reg, rd_s_reg;
    logic [LEN_W-1:0] s1_f_len_reg, s1_f_hpos_reg, s1_s_len_reg, s1_s_hpos_reg;
    logic             s1_f_hseen_reg, s1_f_dok_reg, s1_s_hseen_reg, s1_s_dok_reg;
    logic [GEN_W-1:0] s1_f_gen_reg, s1_s_gen_reg;
    logic             s1_ovf_reg;

    ricmp_pkg::order_t whole_reg, suf_reg;
    ricmp_pkg::order_t out_order_reg;
    logic              out_valid_reg, out_too_long_reg;

    logic       in_second, in_has, in_last, accept, clr, res;
    logic [7:0] in_byte;

    logic [LEN_W-1:0] c_len, c_hpos, t_hpos;
    logic             c_hseen, c_dok, t_hseen, t_dok;
    logic [GEN_W-1:0] c_gen, t_gen;
    logic             pos_ok, take;
    logic             whole_en, suf_en;
    logic [LEN_W:0]   i1;
    logic [AW-1:0]    addr_w, addr_s;
    logic             s1_adv;

    assign in_second = s_axis_tuser[0];
    assign in_byte   = s_axis_tdata[7:0];
    assign in_has    = s_axis_tdata[8];
    assign in_last   = s_axis_tlast;

    assign s1_adv        = !(s1_valid_reg && s1_res_reg && out_valid_reg && !m_axis_tready);
    assign s_axis_tready = s1_adv;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign clr = !in_second && closed_reg;
    assign res = in_second && in_last;

    always_comb
    begin
        f_len_next   = clr ? '0 : f_len_reg;
        f_hpos_next  = clr ? '0 : f_hpos_reg;
        f_hseen_next = clr ? 1'b0 : f_hseen_reg;
        f_gen_next   = clr ? '0 : f_gen_reg;
        f_dok_next   = clr ? 1'b1 : f_dok_reg;
        ovf_next     = clr ? 1'b0 : ovf_reg;
        s_len_next   = clr ? '0 : s_len_reg;
        s_hpos_next  = clr ? '0 : s_hpos_reg;
        s_hseen_next = clr ? 1'b0 : s_hseen_reg;
        s_gen_next   = clr ? '0 : s_gen_reg;
        s_dok_next   = clr ? 1'b1 : s_dok_reg;
        closed_next  = in_second ? 1'b1 : in_last;

        c_len   = in_second ? s_len_reg   : f_len_next;
        c_hpos  = in_second ? s_hpos_reg  : f_hpos_next;
        c_hseen = in_second ? s_hseen_reg : f_hseen_next;
        c_gen   = in_second ? s_gen_reg   : f_gen_next;
        c_dok   = in_second ? s_dok_reg   : f_dok_next;

        t_hpos  = c_hpos;
        t_hseen = c_hseen;
        t_gen   = c_gen;
        t_dok   = c_dok;
        if (!c_hseen)
        begin
            if (in_byte == ricmp_pkg::HYPHEN)
            begin
                t_hseen = 1'b1;
                t_hpos  = c_len;
            end
            else if (in_byte >= ricmp_pkg::DIGIT_LOW && in_byte <= ricmp_pkg::DIGIT_HIGH
                     && c_len < LEN_W'(GEN_DIGITS))
            begin
                t_gen = (c_gen << 3) + (c_gen << 1) + GEN_W'(in_byte[3:0]);
            end
            else
            begin
                t_dok = 1'b0;
            end
        end

        pos_ok = c_len < LEN_W'(MAX_LEN);
        take   = in_has && pos_ok;
        if (in_has && !pos_ok)
        begin
            ovf_next = 1'b1;
        end

        if (take)
        begin
            if (in_second)
            begin
                s_len_next   = c_len + 1'b1;
                s_hpos_next  = t_hpos;
                s_hseen_next = t_hseen;
                s_gen_next   = t_gen;
                s_dok_next   = t_dok;
            end
            else
            begin
                f_len_next   = c_len + 1'b1;
                f_hpos_next  = t_hpos;
                f_hseen_next = t_hseen;
                f_gen_next   = t_gen;
                f_dok_next   = t_dok;
            end
        end

        i1       = {1'b0, f_hpos_reg} + {1'b0, c_len} - {1'b0, t_hpos};
        whole_en = in_second && take && c_len < f_len_reg;
        suf_en   = in_second && take && t_hseen && f_hseen_reg && c_len > t_hpos
                   && i1 < {1'b0, f_len_reg};
        addr_w   = c_len[AW-1:0];
        addr_s   = i1[AW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (accept && !in_second && take)
        begin
            mem[c_len[AW-1:0]] <= in_byte;
        end
        if (s1_adv)
        begin
            rd_w_reg <= mem[addr_w];
            rd_s_reg <= mem[addr_s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_len_reg   <= '0;
            f_hpos_reg  <= '0;
            f_hseen_reg <= 1'b0;
            f_gen_reg   <= '0;
            f_dok_reg   <= 1'b1;
            s_len_reg   <= '0;
            s_hpos_reg  <= '0;
            s_hseen_reg <= 1'b0;
            s_gen_reg   <= '0;
            s_dok_reg   <= 1'b1;
            closed_reg  <= 1'b0;
            ovf_reg     <= 1'b0;
        end
        else if (accept)
        begin
            if (res)
            begin
                f_len_reg   <= '0;
                f_hpos_reg  <= '0;
                f_hseen_reg <= 1'b0;
                f_gen_reg   <= '0;
                f_dok_reg   <= 1'b1;
                s_len_reg   <= '0;
                s_hpos_reg  <= '0;
                s_hseen_reg <= 1'b0;
                s_gen_reg   <= '0;
                s_dok_reg   <= 1'b1;
                closed_reg  <= 1'b0;
                ovf_reg     <= 1'b0;
            end
            else
            begin
                f_len_reg   <= f_len_next;
                f_hpos_reg  <= f_hpos_next;
                f_hseen_reg <= f_hseen_next;
                f_gen_reg   <= f_gen_next;
                f_dok_reg   <= f_dok_next;
                s_len_reg   <= s_len_next;
                s_hpos_reg  <= s_hpos_next;
                s_hseen_reg <= s_hseen_next;
                s_gen_reg   <= s_gen_next;
                s_dok_reg   <= s_dok_next;
                closed_reg  <= closed_next;
                ovf_reg     <= ovf_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s1_clr_reg      <= clr;
            s1_res_reg      <= res;
            s1_whole_en_reg <= whole_en;
            s1_suf_en_reg   <= suf_en;
            s1_byte_reg     <= in_byte;
            s1_f_len_reg    <= f_len_next;
            s1_f_hpos_reg   <= f_hpos_next;
            s1_f_hseen_reg  <= f_hseen_next;
            s1_f_gen_reg    <= f_gen_next;
            s1_f_dok_reg    <= f_dok_next;
            s1_s_len_reg    <= s_len_next;
            s1_s_hpos_reg   <= s_hpos_next;
            s1_s_hseen_reg  <= s_hseen_next;
            s1_s_gen_reg    <= s_gen_next;
            s1_s_dok_reg    <= s_dok_next;
            s1_ovf_reg      <= ovf_next;
        end
    end

    ricmp_pkg::order_t whole_upd, suf_upd, gen_cmp, suf_len_cmp, len_cmp, final_order;
    logic              f_proper, s_proper, numeric;
    logic [LEN_W-1:0]  f_suf_len, s_suf_len;

    always_comb
    begin
        whole_upd = whole_reg;
        if (whole_reg == ricmp_pkg::ORD_EQ && s1_whole_en_reg)
        begin
            whole_upd = ricmp_pkg::byte_cmp(rd_w_reg, s1_byte_reg);
        end
        suf_upd = suf_reg;
        if (suf_reg == ricmp_pkg::ORD_EQ && s1_suf_en_reg)
        begin
            suf_upd = ricmp_pkg::byte_cmp(rd_s_reg, s1_byte_reg);
        end

        f_proper = s1_f_hseen_reg && s1_f_hpos_reg <= LEN_W'(GEN_DIGITS)
                   && s1_f_dok_reg && s1_f_gen_reg != '0;
        s_proper = s1_s_hseen_reg && s1_s_hpos_reg <= LEN_W'(GEN_DIGITS)
                   && s1_s_dok_reg && s1_s_gen_reg != '0;
        numeric  = f_proper && s_proper
                   && !(s1_f_hpos_reg == LEN_W'(1) && s1_s_hpos_reg == LEN_W'(1));

        if (s1_f_gen_reg < s1_s_gen_reg)
        begin
            gen_cmp = ricmp_pkg::ORD_LT;
        end
        else if (s1_f_gen_reg > s1_s_gen_reg)
        begin
            gen_cmp = ricmp_pkg::ORD_GT;
        end
        else
        begin
            gen_cmp = ricmp_pkg::ORD_EQ;
        end

        f_suf_len = s1_f_len_reg - s1_f_hpos_reg;
        s_suf_len = s1_s_len_reg - s1_s_hpos_reg;
        if (f_suf_len < s_suf_len)
        begin
            suf_len_cmp = ricmp_pkg::ORD_LT;
        end
        else if (f_suf_len > s_suf_len)
        begin
            suf_len_cmp = ricmp_pkg::ORD_GT;
        end
        else
        begin
            suf_len_cmp = ricmp_pkg::ORD_EQ;
        end

        if (s1_f_len_reg < s1_s_len_reg)
        begin
            len_cmp = ricmp_pkg::ORD_LT;
        end
        else if (s1_f_len_reg > s1_s_len_reg)
        begin
            len_cmp = ricmp_pkg::ORD_GT;
        end
        else
        begin
            len_cmp = ricmp_pkg::ORD_EQ;
        end

        if (numeric)
        begin
            if (gen_cmp != ricmp_pkg::ORD_EQ)
            begin
                final_order = gen_cmp;
            end
            else if (suf_upd != ricmp_pkg::ORD_EQ)
            begin
                final_order = suf_upd;
            end
            else
            begin
                final_order = suf_len_cmp;
            end
        end
        else if (whole_upd != ricmp_pkg::ORD_EQ)
        begin
            final_order = whole_upd;
        end
        else
        begin
            final_order = len_cmp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            whole_reg <= ricmp_pkg::ORD_EQ;
            suf_reg   <= ricmp_pkg::ORD_EQ;
        end
        else if (s1_valid_reg && s1_adv)
        begin
            if (s1_clr_reg || s1_res_reg)
            begin
                whole_reg <= ricmp_pkg::ORD_EQ;
                suf_reg   <= ricmp_pkg::ORD_EQ;
            end
            else
            begin
                whole_reg <= whole_upd;
                suf_reg   <= suf_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_valid_reg && s1_res_reg && s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s1_res_reg && s1_adv)
        begin
            out_order_reg    <= s1_ovf_reg ? ricmp_pkg::ORD_EQ : final_order;
            out_too_long_reg <= s1_ovf_reg;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = {6'b0, out_order_reg};
    assign m_axis_tuser[0] = out_too_long_reg;

    a_rise_from_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg && s1_res_reg))
        else $error("result beat without a closing second-ID beat");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (s1_valid_reg && s1_res_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled without a blocked result");

    a_too_long_order: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_too_long_reg) |-> (out_order_reg == ricmp_pkg::ORD_EQ))
        else $error("overflow result carries a nonzero order");

    a_clear_after_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && res) |=> (f_len_reg == '0 && s_len_reg == '0 && !closed_reg && !ovf_reg))
        else $error("tracking state not cleared after a pair");

    a_order_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_order_reg != 2'sb10))
        else $error("order outside -1..+1");

endmodule
